[design/cpfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool free list allocator package
// Shared types, field widths, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package cpfl_pkg;

   localparam int DEF_CELLS   = 1024;
   localparam int INDEX_WIDTH = 10;
   localparam int STATUS_WIDTH = 2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_IDX = 2'd2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LINK
   } state_type;

endpackage

[design/cpfl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool free list allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpfl_req_if
   import cpfl_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [INDEX_WIDTH-1:0] free_index;

   modport source (output valid, output command, output free_index, input ready);
   modport sink   (input valid, input command, input free_index, output ready);
endinterface

interface cpfl_rsp_if
   import cpfl_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [INDEX_WIDTH-1:0]  granted_index;
   logic [STATUS_WIDTH-1:0] status;
   logic [INDEX_WIDTH-1:0]  used_count;

   modport source (output valid, output granted_index, output status, output used_count,
                   input ready);
   modport sink   (input valid, input granted_index, input status, input used_count,
                   output ready);
endinterface

[design/cpfl_link_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool link store
// Single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module cpfl_link_mem
   import cpfl_pkg::*;
#(
   parameter int DEPTH = DEF_CELLS,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/cpfl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool free list controller
// Clears the link store, then runs allocate and free commands against it.
// ----------------------------------------------------------------------------
module cpfl_ctrl
   import cpfl_pkg::*;
#(
   parameter int CELLS = DEF_CELLS,
   parameter int ADDR_W = $clog2(CELLS),
   parameter int DATA_W = $clog2(CELLS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   cpfl_req_if.sink          req,
   cpfl_rsp_if.source        rsp,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [DATA_W-1:0] mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [DATA_W-1:0] mem_rd_data
);

   localparam int FW = (DATA_W > INDEX_WIDTH) ? DATA_W : INDEX_WIDTH;
   localparam int CW = (ADDR_W > INDEX_WIDTH) ? ADDR_W : INDEX_WIDTH;

   state_type state_ff, state_in;
   logic [DATA_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              cmd_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0]  grant_ff, grant_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [INDEX_WIDTH-1:0]  used_ff, used_in;

   logic [FW-1:0] idx_w;
   logic [FW-1:0] head_w;
   logic [CW-1:0] count_w;
   logic          out_free;
   logic          free_ok;
   logic          below;
   logic          full;
   logic          accept;

   assign idx_w    = FW'(idx_ff);
   assign head_w   = FW'(head_ff);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign free_ok  = (idx_w != '0) && (idx_w < FW'(CELLS));
   assign below    = idx_w < head_w;
   assign full     = (count_ff >= ADDR_W'(CELLS - 1)) || (head_ff == '0) ||
                     (head_w >= FW'(CELLS));
   assign accept   = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               if (cmd_ff == CMD_FREE && free_ok && !below) begin
                  state_in = ST_LINK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req.ready    = (state_ff == ST_IDLE);
      mem_rd_addr  = head_ff[ADDR_W-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_w[ADDR_W-1:0];
      mem_wr_data  = head_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      grant_in     = grant_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      count_w      = CW'(count_ff);
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               grant_in     = '0;
               status_in    = STATUS_OK;
               if (cmd_ff == CMD_ALLOC) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     grant_in = head_w[INDEX_WIDTH-1:0];
                     head_in  = (mem_rd_data == '0) ? head_ff + 1'b1 : mem_rd_data;
                     count_in = count_ff + 1'b1;
                  end
               end else if (!free_ok) begin
                  status_in = STATUS_BAD_IDX;
               end else begin
                  mem_wr_en = 1'b1;
                  if (below) begin
                     mem_wr_data = head_ff;
                     head_in     = idx_w[DATA_W-1:0];
                  end else begin
                     mem_wr_data = mem_rd_data;
                  end
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
               count_w = CW'(count_in);
               used_in = count_w[INDEX_WIDTH-1:0];
            end
         end
         ST_LINK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = head_ff[ADDR_W-1:0];
            mem_wr_data = idx_w[DATA_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         head_ff      <= DATA_W'(1);
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req.command;
         idx_ff <= req.free_index;
      end
      grant_ff  <= grant_in;
      status_ff <= status_in;
      used_ff   <= used_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.granted_index = grant_ff;
   assign rsp.status        = status_ff;
   assign rsp.used_count    = used_ff;

endmodule

[design/cell_pool_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool free list allocator
// Hands out and takes back cells 1..CELLS-1 through a linked free list that
// lives in a single-port-write, registered-read link store.
//
//   Channel | Dir | Beat contents
//   req     | in  | command, free_index
//   rsp     | out | granted_index, status, used_count
//
// An allocate or a free runs through the IDLE and EXEC states, with the head
// cell's link taken from the registered read; a free that lands behind the head
// adds a LINK state for its second link store write. After reset the link store
// is cleared, one entry a cycle, before req is ready. A stalled rsp beat is
// held in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module cell_pool_free_list_allocator
   import cpfl_pkg::*;
#(
   parameter int CELLS = DEF_CELLS
) (
   input  logic       clock,
   input  logic       reset,
   cpfl_req_if.sink   req,
   cpfl_rsp_if.source rsp
);

   localparam int ADDR_W = $clog2(CELLS);
   localparam int DATA_W = $clog2(CELLS + 1);

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   cpfl_ctrl #(
      .CELLS  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cpfl_link_mem #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
